[design/pss_pkg.sv]
// Shared types and constants for the pattern step sequencer.
// No dependencies; imported by pss_ram users and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pss_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned LEN_W   = ADDR_W + 1;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RPOS_W  = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TRIG  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // Play modes
  localparam logic [1:0] PLAY_RUN   = 2'd0;
  localparam logic [1:0] PLAY_LOOP  = 2'd1;
  localparam logic [1:0] PLAY_PAUSE = 2'd2;
  localparam logic [1:0] PLAY_STOP  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]                mode;
    logic [9:0]                index;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      empty_res;
    logic [9:0]                position;
  } out_t;

endpackage
`default_nettype wire

[design/pss_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/pattern_step_sequencer_unit.sv]
// Top level of the pattern step sequencer: item decode, position update,
// pattern memory and result register. Depends on pss_pkg and pss_ram.
`timescale 1ns / 1ps
`default_nettype none
// A pattern of up to DEPTH Q16.16 values is loaded one element per load item
// into a synchronous pattern RAM; trigger items move the play position and
// return the value found there, reset items arm a pending reset that lands on
// the next trigger. Load and reset items are taken one per cycle while
// in_ready is high. A trigger works out the new position and issues the RAM
// read in the accept cycle; the read data passes through the RAM's read
// register into the result register, and no new item is taken while that
// read is in flight. A result waiting in the result register holds off new
// items; the next item can be taken in the cycle that result transfers.
// No clearing pass is needed after reset: unwritten elements read as
// whatever the RAM holds. The user writes configuration (cfg_we/cfg_index/
// cfg_data) only while the block is idle; the block does not enforce this.
module pattern_step_sequencer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // item input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire pss_pkg::in_t                   in_data,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output pss_pkg::out_t                       out_data,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pss_pkg::CFG_W-1:0]      cfg_data
);
  import pss_pkg::*;

  // Configuration registers
  logic [1:0]               play_mode;
  logic                     direction;
  logic signed [RPOS_W-1:0] reset_position;
  logic                     idle_empty;

  // Sequencer state
  logic [LEN_W-1:0]  pattern_length;
  logic [ADDR_W-1:0] position;
  logic              reset_pending;

  // Read in flight and its side data
  logic              rd_pend;
  logic              pend_zero;
  logic              pend_empty;
  logic [ADDR_W-1:0] pend_pos;

  logic [VALUE_W-1:0] ram_rdata;

  logic in_xfer, out_xfer;
  logic is_load, is_trig, is_reset;

  // Position datapath, one bit of headroom either way
  logic [LEN_W-1:0]         limit;
  logic signed [LEN_W:0]    lim_s, last_s, cur_s, rp_s, step_s, p1, p2, p_clip;
  logic                     fwd, idle1, idle2;
  logic [ADDR_W-1:0]        position_next;

  // Slot for a new read exists when none is in flight and the result register
  // is empty or being drained this cycle.
  assign in_ready = !rd_pend && (!out_valid || out_ready);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  assign is_load  = in_xfer && (in_data.mode == MODE_LOAD);
  assign is_trig  = in_xfer && (in_data.mode == MODE_TRIG);
  assign is_reset = in_xfer && (in_data.mode == MODE_RESET);

  always_comb begin
    limit  = (pattern_length == '0) ? LEN_W'(1) : pattern_length;
    lim_s  = signed'({1'b0, limit});
    last_s = lim_s - (LEN_W + 1)'(1);
    cur_s  = signed'({2'b00, position});
    rp_s   = (LEN_W + 1)'(reset_position);
    fwd    = (direction == 1'b0);
    step_s = fwd ? cur_s + (LEN_W + 1)'(1) : cur_s - (LEN_W + 1)'(1);
    idle1  = 1'b0;
    p1     = cur_s;

    case (play_mode)
      PLAY_RUN: begin
        p1 = step_s;
      end
      PLAY_LOOP: begin
        if (fwd) begin
          p1 = (step_s < lim_s) ? step_s : '0;
        end else begin
          p1 = (step_s < 0) ? last_s : step_s;
        end
      end
      PLAY_PAUSE: begin
        idle1 = 1'b1;
      end
      default: begin
        p1    = rp_s;
        idle1 = 1'b1;
      end
    endcase

    // pending reset overrides the play-mode move; -1 picks an end by direction
    p2 = p1;
    if (reset_pending) begin
      if (rp_s == -1) begin
        p2 = fwd ? '0 : last_s;
      end else begin
        p2 = rp_s;
      end
    end

    idle2 = idle1;
    if (play_mode == PLAY_RUN) begin
      idle2 = (p2 < 0) || (p2 >= lim_s);
    end

    p_clip = p2;
    if (p2 < 0) begin
      p_clip = '0;
    end else if (p2 > last_s) begin
      p_clip = last_s;
    end
    position_next = p_clip[ADDR_W-1:0];
  end

  pss_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_pattern (
    .clk   (clk),
    .we    (is_load),
    .waddr (in_data.index),
    .wdata (in_data.value),
    .re    (is_trig),
    .raddr (position_next),
    .rdata (ram_rdata)
  );

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode      <= PLAY_RUN;
      direction      <= 1'b0;
      reset_position <= '1;
      idle_empty     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAY_MODE:  play_mode      <= cfg_data[1:0];
        REG_DIRECTION:  direction      <= cfg_data[0];
        REG_RESET_POS:  reset_position <= signed'(cfg_data[RPOS_W-1:0]);
        REG_IDLE_EMPTY: idle_empty     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer state and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      position       <= '0;
      reset_pending  <= 1'b1;
      rd_pend        <= 1'b0;
    end else begin
      rd_pend <= is_trig;
      if (is_load && in_data.last) begin
        pattern_length <= LEN_W'(in_data.index) + LEN_W'(1);
      end
      if (is_reset) begin
        reset_pending <= 1'b1;
      end
      if (is_trig) begin
        reset_pending <= 1'b0;
        position      <= position_next;
      end
    end
  end

  // side data for the read in flight
  always_ff @(posedge clk) begin
    if (is_trig) begin
      pend_empty <= idle2 && idle_empty;
      pend_zero  <= (idle2 && idle_empty) || (pattern_length == '0);
      pend_pos   <= position_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_data.value_res <= pend_zero ? '0 : signed'(ram_rdata);
      out_data.empty_res <= pend_empty;
      out_data.position  <= pend_pos;
    end
  end

  // Checks
  // a landing read always finds the result register free
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // each accepted trigger yields a valid result once its RAM read has landed
  a_trig_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.mode == MODE_TRIG) |=> ##1 out_valid)
    else $error("trigger without result");

  // an empty result carries a zero value
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_res) |-> (out_data.value_res == '0))
    else $error("empty result with value");

  // no new item while a read is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !in_ready)
    else $error("item taken during read");

endmodule
`default_nettype wire

[sim/pattern_step_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for pattern_step_sequencer_unit: directed and random item
// traffic, results checked in order against a built-in step predictor.
// Depends on pss_pkg and the pattern_step_sequencer_unit RTL.
module pattern_step_sequencer_unit_tb;
  import pss_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused item mode, ignored
  localparam int RAND_ITEMS = 260;

  // receiver stall styles
  localparam int RX_FULL   = 0;
  localparam int RX_MOSTLY = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_TOGGLE = 3;
  localparam int RX_HOLD   = 4;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  pattern_step_sequencer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predictor state: pattern, length, play position and the armed reset,
  // plus a copy of the four registers.
  logic [VALUE_W-1:0] pat_mem [DEPTH];
  bit                 loaded  [DEPTH];
  int                 prefix_len;      // elements 0..prefix_len-1 all written
  logic [LEN_W-1:0]   pat_len;
  logic [ADDR_W-1:0]  cur_pos;
  bit                 reset_armed;
  logic [1:0]         play_cfg;
  bit                 dir_cfg;
  int                 rpos_cfg;
  bit                 idle_empty_cfg;

  out_t expected_steps [$];
  int   errors;
  int   item_count;
  int   burst_left;
  bit   gaps_on;
  int   rx_style;
  int   rx_left = 0;

  // Move the position for one trigger and form the result it gives.
  function automatic out_t next_step_result();
    int   limit;
    int   pos;
    bit   fwd;
    bit   idle;
    bit   empty;
    out_t r;
    limit = (pat_len != 0) ? int'(pat_len) : 1;
    pos = int'(cur_pos);
    fwd = !dir_cfg;
    idle = 1'b0;
    case (play_cfg)
      PLAY_RUN: pos = fwd ? pos + 1 : pos - 1;
      PLAY_LOOP: begin
        if (fwd) pos = (pos + 1 < limit) ? pos + 1 : 0;
        else pos = (pos - 1 < 0) ? limit - 1 : pos - 1;
      end
      PLAY_PAUSE: idle = 1'b1;
      default: begin
        pos = rpos_cfg;
        idle = 1'b1;
      end
    endcase
    // armed reset lands after the play-mode move
    if (reset_armed) begin
      reset_armed = 1'b0;
      pos = (rpos_cfg == -1) ? (fwd ? 0 : limit - 1) : rpos_cfg;
    end
    if (play_cfg == PLAY_RUN) idle = (pos < 0) || (pos >= limit);
    if (pos < 0) pos = 0;
    if (pos > limit - 1) pos = limit - 1;
    cur_pos = pos[ADDR_W-1:0];
    empty = idle && idle_empty_cfg;
    r.empty_res = empty;
    r.position = cur_pos;
    r.value_res = (!empty && pat_len != 0) ? pat_mem[cur_pos] : '0;
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_t load_item(int idx, logic [VALUE_W-1:0] v, bit last);
    in_t r;
    r.mode = MODE_LOAD;
    r.index = idx[9:0];
    r.value = v;
    r.last = last;
    return r;
  endfunction

  // trigger, reset or spare item: the other fields carry noise
  function automatic in_t ctl_item(logic [1:0] mode);
    in_t r;
    r.mode = mode;
    r.index = 10'($urandom());
    r.value = $urandom();
    r.last = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // One item transfer; the predictor runs at the accepting edge.
  task automatic send_item(input in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (item.mode != MODE_SPARE) item_count++;
    case (item.mode)
      MODE_LOAD: begin
        pat_mem[item.index] = item.value;
        loaded[item.index] = 1'b1;
        if (item.last) pat_len = LEN_W'(item.index) + 1'b1;
        while (prefix_len < DEPTH && loaded[prefix_len]) prefix_len++;
      end
      MODE_RESET: reset_armed = 1'b1;
      MODE_TRIG: expected_steps.push_back(next_step_result());
      default: ;
    endcase
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Hold the sender until every expected result has been transferred,
  // then let in-flight loads and resets settle.
  task automatic wait_idle();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (expected_steps.size() != 0 && n < 3000) begin
      @(negedge clk);
      n++;
    end
    if (expected_steps.size() != 0) begin
      $error("%0d expected results never arrived", expected_steps.size());
      errors++;
      expected_steps.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_PLAY_MODE:  play_cfg = data[1:0];
      REG_DIRECTION:  dir_cfg = data[0];
      REG_RESET_POS:  rpos_cfg = int'($signed(data));
      REG_IDLE_EMPTY: idle_empty_cfg = data[0];
      default: ;
    endcase
  endtask

  // unused upper bits carry noise; the block must mask them
  task automatic program_config(input logic [1:0] play, input bit dir, input int rpos,
                                input bit ide);
    write_reg(REG_PLAY_MODE, {9'($urandom()), play});
    write_reg(REG_DIRECTION, {10'($urandom()), dir});
    write_reg(REG_RESET_POS, rpos[CFG_W-1:0]);
    write_reg(REG_IDLE_EMPTY, {10'($urandom()), ide});
  endtask

  task automatic test_empty_pattern();
    send_item(ctl_item(MODE_TRIG));   // reset armed from power-up lands on 0
    send_item(ctl_item(MODE_TRIG));   // run steps past the end: idle, repeat
    send_item(ctl_item(MODE_SPARE));  // spare mode gives nothing
    wait_idle();
    program_config(PLAY_RUN, 1'b1, -1, 1'b1);
    send_item(ctl_item(MODE_TRIG));   // backward below 0: idle and empty
  endtask

  task automatic test_load_extremes();
    wait_idle();
    program_config(PLAY_RUN, 1'b0, -1, 1'b0);
    send_item(load_item(0, 32'h8000_0000, 1'b0));
    send_item(load_item(1, 32'h7FFF_FFFF, 1'b0));
    send_item(load_item(2, 32'h0000_0000, 1'b0));
    send_item(load_item(3, 32'hFFFF_FFFF, 1'b1));
    send_item(load_item(DEPTH - 1, 32'h5555_AAAA, 1'b0));  // top index, length kept
    repeat (4) send_item(ctl_item(MODE_TRIG));  // 1, 2, 3, then idle at the end
    send_item(ctl_item(MODE_RESET));
    send_item(ctl_item(MODE_TRIG));
  endtask

  task automatic test_play_modes();
    wait_idle();
    program_config(PLAY_LOOP, 1'b0, -1, 1'b0);
    repeat (4) send_item(ctl_item(MODE_TRIG));  // wraps past the last element
    wait_idle();
    program_config(PLAY_LOOP, 1'b1, -1, 1'b0);
    send_item(ctl_item(MODE_TRIG));             // wraps below zero
    wait_idle();
    program_config(PLAY_PAUSE, 1'b0, -1, 1'b1);
    send_item(ctl_item(MODE_TRIG));             // pause holds, empty frame
    wait_idle();
    program_config(PLAY_STOP, 1'b1, -1, 1'b0);
    send_item(ctl_item(MODE_TRIG));             // stop at -1 clips to 0, even backward
    wait_idle();
    program_config(PLAY_STOP, 1'b0, -5, 1'b1);
    send_item(ctl_item(MODE_RESET));
    send_item(ctl_item(MODE_TRIG));             // negative position clips to 0
    wait_idle();
    program_config(PLAY_RUN, 1'b1, 1000, 1'b0);
    send_item(ctl_item(MODE_RESET));
    send_item(ctl_item(MODE_TRIG));             // past the pattern: last element
  endtask

  task automatic test_full_depth();
    wait_idle();
    program_config(PLAY_LOOP, 1'b0, DEPTH - 1, 1'b0);
    gaps_on = 1'b0;
    for (int i = 0; i < DEPTH; i++) send_item(load_item(i, rand_value(), i == DEPTH - 1));
    send_item(ctl_item(MODE_RESET));
    repeat (2) send_item(ctl_item(MODE_TRIG));  // top element, then wrap to 0
    wait_idle();
    program_config(PLAY_RUN, 1'b1, -1, 1'b1);
    send_item(ctl_item(MODE_RESET));
    repeat (2) send_item(ctl_item(MODE_TRIG));  // last element, then one below
    gaps_on = 1'b1;
  endtask

  // Phases of random traffic, each under a fresh register setting. Most of it
  // is pattern loads followed by trigger runs; the rest is noise.
  task automatic test_random_traffic();
    int         stop_at;
    int         phase_end;
    int         n;
    int         idx;
    int         rpos;
    logic [1:0] mode;
    stop_at = item_count + RAND_ITEMS;
    while (item_count < stop_at) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0: rpos = -1;
        1: rpos = 0;
        2: rpos = DEPTH - 1;
        3: rpos = -1024;
        4: rpos = -int'($urandom_range(2, 1024));
        5: rpos = (pat_len != 0) ? int'(pat_len) - 1 : 0;
        6: rpos = $urandom_range(0, int'(pat_len) + 2);
        default: rpos = -1;
      endcase
      program_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rpos,
                     1'($urandom_range(0, 1)));
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_end = item_count + $urandom_range(60, 140);
      while (item_count < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // fresh pattern, mostly short
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            for (int i = 0; i < n; i++) send_item(load_item(i, rand_value(), i == n - 1));
          end
          2, 3, 4, 5, 6, 7: begin
            n = $urandom_range(1, 20);
            repeat (n) begin
              if ($urandom_range(0, 9) == 0) send_item(ctl_item(MODE_RESET));
              send_item(ctl_item(MODE_TRIG));
            end
          end
          8: begin
            send_item(ctl_item(MODE_RESET));
            repeat ($urandom_range(1, 4)) send_item(ctl_item(MODE_TRIG));
          end
          default: begin
            repeat ($urandom_range(1, 6)) begin
              mode = 2'($urandom_range(0, 3));
              if (mode == MODE_LOAD) begin
                idx = $urandom_range(0, DEPTH - 1);
                // a length mark only where every element below is written
                send_item(load_item(idx, rand_value(),
                                    $urandom_range(0, 1) && idx <= prefix_len));
              end else begin
                send_item(ctl_item(mode));
              end
            end
          end
        endcase
      end
    end
  endtask

  // Receiver: ready follows a style that changes every so often.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(RX_FULL, RX_HOLD);
      rx_left = (rx_style == RX_HOLD) ? $urandom_range(3, 40) : $urandom_range(10, 150);
    end
    rx_left--;
    case (rx_style)
      RX_FULL:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      RX_TOGGLE: out_ready <= ~out_ready;
      default:   out_ready <= 1'b0;
    endcase
  end

  // Each result transfer against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_steps.size() == 0) begin
        $error("result transfer with nothing expected: value_res %h position %0d",
               out_data.value_res, out_data.position);
        errors++;
      end else begin
        want = expected_steps.pop_front();
        if (out_data.value_res !== want.value_res) begin
          $error("value_res: expected %h, got %h", want.value_res, out_data.value_res);
          errors++;
        end
        if (out_data.empty_res !== want.empty_res) begin
          $error("empty_res: expected %b, got %b", want.empty_res, out_data.empty_res);
          errors++;
        end
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_data.position);
          errors++;
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("pattern_step_sequencer_unit_tb: errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < DEPTH; i++) loaded[i] = 1'b0;
    prefix_len = 0;
    pat_len = '0;
    cur_pos = '0;
    reset_armed = 1'b1;
    play_cfg = PLAY_RUN;
    dir_cfg = 1'b0;
    rpos_cfg = -1;
    idle_empty_cfg = 1'b0;
    errors = 0;
    item_count = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_pattern();
    test_load_extremes();
    test_play_modes();
    test_full_depth();
    test_random_traffic();
    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0) $display("pattern_step_sequencer_unit_tb: clean");
    else $display("pattern_step_sequencer_unit_tb: errors");
    $finish;
  end

endmodule
